FILE: hdl/assert_macros.svh
// Assertion macros shared by the slice band packer RTL.
// Depends on nothing; each macro is empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SLBP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("slbp assertion failed");
`define SLBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("slbp assertion failed");
`else
`define SLBP_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SLBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/slbp_pkg.sv
// Package for the slice band packer: action codes and sequencer states.
// Depends on nothing.
`timescale 1ns / 1ps
package slbp_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_PLACE = 2'd1,
    ACT_CHECK = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SRCH,
    ST_CHK,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_END,
    ST_REM_RD,
    ST_REM_WR,
    ST_SZ_MUL,
    ST_SZ_CMP,
    ST_FIN
  } state_t;

endpackage

FILE: hdl/slice_band_rect_packer.sv
// Slice band rectangle packer top level: sequencer, band list and extents.
// Depends on slbp_pkg, slbp_band_ram and assert_macros.svh.
//
//   channel | ports                                         | direction
//   in_     | action rect_width rect_height allow_shrink    | request in
//   out_    | placed pos_x pos_y need_* resize_needed empty | result out
//
// A clear or unused action goes straight to the finish state; a size check
// multiplies, then compares. A place turns the size into slices, reads bands
// in turn, moves bands by a read and a write when the list opens or closes,
// then writes any leftover strip in; the band memory's one read port sets this.
// Reset is synchronous; the list then reads as one full band without a sweep.
// One request is in work at a time; a waiting result holds off the next one.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module slice_band_rect_packer #(
  parameter int GRID_SLICES  = 32,
  parameter int SLICE_PIXELS = 128,
  parameter int MAX_BANDS    = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [12:0] in_rect_width,
  input  logic [12:0] in_rect_height,
  input  logic        in_allow_shrink,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_placed,
  output logic [11:0] out_pos_x,
  output logic [11:0] out_pos_y,
  output logic [12:0] out_need_width,
  output logic [12:0] out_need_height,
  output logic        out_resize_needed,
  output logic        out_plane_empty
);
  import slbp_pkg::*;

  localparam int SW = $clog2(GRID_SLICES + 2);
  localparam int BW = 4 * SW;
  localparam int IW = $clog2(MAX_BANDS);
  localparam int CW = $clog2(MAX_BANDS + 1);
  localparam int AW = 2 * SW;
  localparam longint unsigned RECIP = ((64'd1 << 32) + SLICE_PIXELS - 1) / SLICE_PIXELS;
  localparam logic [15:0] GRID_PIX = 16'(GRID_SLICES * SLICE_PIXELS);
  localparam logic [BW-1:0] FULL_BAND = {SW'(0), SW'(0), SW'(GRID_SLICES), SW'(GRID_SLICES)};

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            first_ok_r, first_ok_nxt;
  logic [SW-1:0]   need_w_r, need_w_nxt, need_h_r, need_h_nxt;
  logic [SW-1:0]   tex_w_r, tex_w_nxt, tex_h_r, tex_h_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [12:0]     rw_r, rw_nxt, rh_r, rh_nxt;
  logic            shrink_r, shrink_nxt;
  logic [SW-1:0]   sw_r, sw_nxt, sh_r, sh_nxt;
  logic [IW-1:0]   idx_r, idx_nxt, j_r, j_nxt, ins_at_r, ins_at_nxt;
  logic [BW-1:0]   strip_r, strip_nxt;
  logic            placed_r, placed_nxt, resize_r, resize_nxt;
  logic [SW-1:0]   px_r, px_nxt, py_r, py_nxt;
  logic [AW-1:0]   area_n_r, area_n_nxt, area_t_r, area_t_nxt;
  logic            rd0_r;
  logic            o_placed_r, o_resize_r, o_empty_r;
  logic [11:0]     o_x_r, o_y_r;
  logic [12:0]     o_nw_r, o_nh_r;

  logic            ram_we, ram_re;
  logic [IW-1:0]   ram_wa, ram_ra;
  logic [BW-1:0]   ram_wd, ram_rd, band_in;
  logic [SW-1:0]   bx, by, bw, bh;
  logic [13:0]     vw, vh;
  logic [45:0]     pw, ph;
  logic            fit, wide, tall;
  logic [CW-1:0]   next_pos;
  logic            load_out;

  slbp_band_ram #(.DEPTH(MAX_BANDS), .WIDTH(BW)) u_ram (
    .clk(clk), .we(ram_we), .wa(ram_wa), .wd(ram_wd),
    .re(ram_re), .ra(ram_ra), .rd(ram_rd)
  );

  assign band_in = (rd0_r && !first_ok_r) ? FULL_BAND : ram_rd;
  assign {bx, by, bw, bh} = band_in;
  assign fit  = (sw_r <= bw) && (sh_r <= bh);
  assign wide = bw > sw_r;
  assign tall = sh_r < bh;
  assign next_pos = CW'(idx_r) + CW'(1);
  assign vw = 14'(rw_r) + 14'(SLICE_PIXELS - 1);
  assign vh = 14'(rh_r) + 14'(SLICE_PIXELS - 1);
  assign pw = 46'(vw) * 46'(RECIP);
  assign ph = 46'(vh) * 46'(RECIP);
  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;

  always_comb begin
    state_nxt = state_r;   count_nxt = count_r;   first_ok_nxt = first_ok_r;
    need_w_nxt = need_w_r; need_h_nxt = need_h_r; tex_w_nxt = tex_w_r;
    tex_h_nxt = tex_h_r;   rw_nxt = rw_r;
    rh_nxt = rh_r;         shrink_nxt = shrink_r; sw_nxt = sw_r;
    sh_nxt = sh_r;         idx_nxt = idx_r;       j_nxt = j_r;
    ins_at_nxt = ins_at_r; strip_nxt = strip_r;   placed_nxt = placed_r;
    resize_nxt = resize_r; px_nxt = px_r;         py_nxt = py_r;
    area_n_nxt = area_n_r; area_t_nxt = area_t_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we = 1'b0; ram_wa = idx_r; ram_wd = band_in;
    ram_re = 1'b0; ram_ra = idx_r;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          rw_nxt = in_rect_width; rh_nxt = in_rect_height;
          shrink_nxt = in_allow_shrink;
          placed_nxt = 1'b0; resize_nxt = 1'b0; px_nxt = '0; py_nxt = '0;
          unique case (action_t'(in_action))
            ACT_CLEAR: begin
              count_nxt = CW'(1); first_ok_nxt = 1'b0;
              need_w_nxt = '0; need_h_nxt = '0;
              state_nxt = ST_FIN;
            end
            ACT_PLACE: state_nxt = ST_DIV;
            ACT_CHECK: state_nxt = ST_SZ_MUL;
            default:   state_nxt = ST_FIN;
          endcase
        end
      end
      ST_DIV: begin
        sw_nxt = ({3'b0, rw_r} > GRID_PIX) ? SW'(GRID_SLICES + 1) : pw[32 +: SW];
        sh_nxt = ({3'b0, rh_r} > GRID_PIX) ? SW'(GRID_SLICES + 1) : ph[32 +: SW];
        idx_nxt = '0;
        state_nxt = (count_r != '0) ? ST_SRCH : ST_FIN;
      end
      ST_SRCH: begin
        ram_re = 1'b1; ram_ra = idx_r;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (fit) begin
          placed_nxt = 1'b1; px_nxt = bx; py_nxt = by;
          if (bx + sw_r > need_w_r) need_w_nxt = bx + sw_r;
          if (by + sh_r > need_h_r) need_h_nxt = by + sh_r;
          strip_nxt = {bx, by + sh_r, bw, bh - sh_r};
          ins_at_nxt = IW'(next_pos);
          state_nxt = ST_FIN;
          ram_wa = idx_r;
          if (wide) begin
            ram_we = 1'b1;
            ram_wd = {bx + sw_r, by, bw - sw_r, sh_r};
            if (tall && (count_r < CW'(MAX_BANDS))) begin
              count_nxt = count_r + CW'(1);
              if (next_pos < count_r) begin
                j_nxt = IW'(count_r - CW'(1));
                state_nxt = ST_INS_RD;
              end else begin
                state_nxt = ST_INS_END;
              end
            end
          end else if (tall) begin
            ram_we = 1'b1;
            ram_wd = {bx, by + sh_r, bw, bh - sh_r};
          end else begin
            count_nxt = count_r - CW'(1);
            if (next_pos < count_r) begin
              j_nxt = idx_r;
              state_nxt = ST_REM_RD;
            end
          end
        end else if (next_pos < count_r) begin
          idx_nxt = IW'(next_pos);
          state_nxt = ST_SRCH;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_INS_RD: begin
        ram_re = 1'b1; ram_ra = j_r;
        state_nxt = ST_INS_WR;
      end
      ST_INS_WR: begin
        ram_we = 1'b1; ram_wa = IW'(CW'(j_r) + CW'(1)); ram_wd = band_in;
        if (j_r == ins_at_r) begin
          state_nxt = ST_INS_END;
        end else begin
          j_nxt = j_r - IW'(1);
          state_nxt = ST_INS_RD;
        end
      end
      ST_INS_END: begin
        ram_we = 1'b1; ram_wa = ins_at_r; ram_wd = strip_r;
        state_nxt = ST_FIN;
      end
      ST_REM_RD: begin
        ram_re = 1'b1; ram_ra = IW'(CW'(j_r) + CW'(1));
        state_nxt = ST_REM_WR;
      end
      ST_REM_WR: begin
        ram_we = 1'b1; ram_wa = j_r; ram_wd = band_in;
        if (CW'(j_r) + CW'(1) == count_r) begin
          state_nxt = ST_FIN;
        end else begin
          j_nxt = j_r + IW'(1);
          state_nxt = ST_REM_RD;
        end
      end
      ST_SZ_MUL: begin
        area_n_nxt = AW'(need_w_r) * AW'(need_h_r);
        area_t_nxt = AW'(tex_w_r) * AW'(tex_h_r);
        state_nxt = ST_SZ_CMP;
      end
      ST_SZ_CMP: begin
        if ((need_w_r > tex_w_r) || (need_h_r > tex_h_r) ||
            (shrink_r && ((AW + 3)'(area_n_r) * (AW + 3)'(5) <
                          (AW + 3)'(area_t_r) * (AW + 3)'(4)))) begin
          resize_nxt = 1'b1; tex_w_nxt = need_w_r; tex_h_nxt = need_h_r;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        load_out = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (ram_we && (ram_wa == '0)) first_ok_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; count_r <= CW'(1); first_ok_r <= 1'b0;
      need_w_r <= '0; need_h_r <= '0; tex_w_r <= '0; tex_h_r <= '0;
      out_valid_r <= 1'b0; rd0_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; first_ok_r <= first_ok_nxt;
      need_w_r <= need_w_nxt; need_h_r <= need_h_nxt;
      tex_w_r <= tex_w_nxt; tex_h_r <= tex_h_nxt;
      out_valid_r <= out_valid_nxt; rd0_r <= ram_re && (ram_ra == '0);
    end
  end

  always_ff @(posedge clk) begin
    rw_r <= rw_nxt; rh_r <= rh_nxt; shrink_r <= shrink_nxt;
    sw_r <= sw_nxt; sh_r <= sh_nxt; idx_r <= idx_nxt; j_r <= j_nxt;
    ins_at_r <= ins_at_nxt; strip_r <= strip_nxt; placed_r <= placed_nxt;
    resize_r <= resize_nxt; px_r <= px_nxt; py_r <= py_nxt;
    area_n_r <= area_n_nxt; area_t_r <= area_t_nxt;
    if (load_out) begin
      o_placed_r <= placed_r;
      o_resize_r <= resize_r;
      o_x_r  <= 12'(21'(px_r) * 21'(SLICE_PIXELS));
      o_y_r  <= 12'(21'(py_r) * 21'(SLICE_PIXELS));
      o_nw_r <= 13'(21'(need_w_r) * 21'(SLICE_PIXELS));
      o_nh_r <= 13'(21'(need_h_r) * 21'(SLICE_PIXELS));
      o_empty_r <= (need_w_r == '0) && (need_h_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_placed = o_placed_r;
  assign out_pos_x = o_x_r;
  assign out_pos_y = o_y_r;
  assign out_need_width = o_nw_r;
  assign out_need_height = o_nh_r;
  assign out_resize_needed = o_resize_r;
  assign out_plane_empty = o_empty_r;

  `SLBP_ASSERT_NOW(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(MAX_BANDS))
  `SLBP_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready)
  `SLBP_ASSERT_NOW(a_chk_in_list, clk, rst_n, state_r == ST_CHK, CW'(idx_r) < count_r)
  `SLBP_ASSERT_NOW(a_need_in_grid, clk, rst_n, 1'b1,
                   need_w_r <= SW'(GRID_SLICES) && need_h_r <= SW'(GRID_SLICES))
  `SLBP_ASSERT_NOW(a_rem_in_list, clk, rst_n, state_r == ST_REM_WR, CW'(j_r) < count_r)

endmodule

FILE: hdl/slbp_band_ram.sv
// Band list memory: one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module slbp_band_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule
